@@ rtl/msas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msas_pkg;

  // Sizes of the running and waiting queues.
  localparam int RunSlots  = 8;
  localparam int WaitDepth = 16;

  localparam int RunIdxW  = (RunSlots > 1) ? $clog2(RunSlots) : 1;
  localparam int RunCntW  = $clog2(RunSlots + 1);
  localparam int WaitIdxW = (WaitDepth > 1) ? $clog2(WaitDepth) : 1;
  localparam int WaitCntW = $clog2(WaitDepth + 1);

  // Fixed field widths.
  localparam int IdW     = 16;
  localparam int MemW    = 16;
  localparam int MaxRunW = 4;
  localparam int JobsW   = 4;
  localparam int CfgW    = 16;

  localparam logic [MaxRunW-1:0] MaxRunReset = MaxRunW'(8);
  localparam logic [MemW-1:0]    MemCapReset = {MemW{1'b1}};

  typedef enum logic [0:0] {
    CMD_CREATE = 1'b0,
    CMD_KILL   = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_MAX_RUNNING = 1'b0,
    CFG_MEM_CAPACITY = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_QUEUED     = 3'd0,
    EV_ADMITTED   = 3'd1,
    EV_KILLED     = 3'd2,
    EV_ADMIT_WAIT = 3'd3,
    EV_REJECTED   = 3'd4,
    EV_NO_KILL    = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_KILL,
    ST_WREAD,
    ST_WCHECK,
    ST_EMIT
  } state_e;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [MemW-1:0] mem;
  } entry_t;

  typedef struct packed {
    logic [MaxRunW-1:0] max_running;
    logic [MemW-1:0]    mem_capacity;
  } cfg_t;

  typedef struct packed {
    alu_op_e         op;
    logic [MemW-1:0] a;
    logic [MemW-1:0] b;
    logic [MemW-1:0] cap;
  } alu_req_t;

  typedef struct packed {
    logic [MemW:0] res;
    logic          le_cap;
    logic          lt_cap;
  } alu_rsp_t;

  typedef struct packed {
    event_e           ev;
    logic [IdW-1:0]   id;
    logic [MemW-1:0]  mem;
    logic [MemW-1:0]  used;
    logic [JobsW-1:0] jobs;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/msas_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared add/subtract unit with the capacity compares on the sum.
module msas_alu import msas_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [MemW:0] sum;
  logic [MemW:0] diff;

  assign sum  = {1'b0, req_i.a} + {1'b0, req_i.b};
  assign diff = {1'b0, req_i.a} - {1'b0, req_i.b};

  always_comb begin
    rsp_o.res    = (req_i.op == ALU_SUB) ? diff : sum;
    rsp_o.le_cap = (sum <= {1'b0, req_i.cap});
    rsp_o.lt_cap = (sum < {1'b0, req_i.cap});
  end

endmodule

`default_nettype wire

@@ rtl/msas_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sequencer that owns both job queues and drives the shared arithmetic unit.
module msas_seq import msas_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            command_i,
  input  logic [IdW-1:0]  job_id_i,
  input  logic [MemW-1:0] job_memory_i,
  input  cfg_t            cfg_i,
  input  logic            out_free_i,
  output logic            emit_valid_o,
  output result_t         emit_o,
  output alu_req_t        alu_req_o,
  input  alu_rsp_t        alu_rsp_i
);

  state_e state_q, state_d;

  logic [IdW-1:0]      jid_q, jid_d;
  logic [MemW-1:0]     jmem_q, jmem_d;
  logic [RunIdxW-1:0]  run_head_q, run_head_d;
  logic [RunCntW-1:0]  run_cnt_q, run_cnt_d;
  logic [WaitIdxW-1:0] wait_head_q, wait_head_d;
  logic [WaitCntW-1:0] wait_cnt_q, wait_cnt_d;
  logic [MemW-1:0]     used_q, used_d;
  result_t             pend_q, pend_d;
  logic                more_q, more_d;

  entry_t run_mem [RunSlots];
  entry_t wait_mem [WaitDepth];
  entry_t run_rd_q;
  entry_t wait_rd_q;

  logic                run_we, wait_we;
  entry_t              run_wdata, wait_wdata;
  logic [RunIdxW-1:0]  run_widx;
  logic [WaitIdxW-1:0] wait_widx;
  logic [RunIdxW:0]    run_sum;
  logic [WaitIdxW:0]   wait_sum;
  logic [RunCntW-1:0]  slot_lim;
  logic                slot_free;
  logic                accept;
  logic [RunIdxW-1:0]  run_head_inc;
  logic [WaitIdxW-1:0] wait_head_inc;

  assign accept = in_valid_i && in_ready_o;

  assign slot_lim  = (32'(cfg_i.max_running) < RunSlots) ?
                     RunCntW'(cfg_i.max_running) : RunCntW'(RunSlots);
  assign slot_free = (run_cnt_q < slot_lim);

  // Tail positions wrap with one compare and subtract.
  assign run_sum  = {1'b0, run_head_q} + (RunIdxW + 1)'(run_cnt_q);
  assign run_widx = (32'(run_sum) >= RunSlots) ?
                    RunIdxW'(32'(run_sum) - RunSlots) : run_sum[RunIdxW-1:0];
  assign wait_sum  = {1'b0, wait_head_q} + (WaitIdxW + 1)'(wait_cnt_q);
  assign wait_widx = (32'(wait_sum) >= WaitDepth) ?
                     WaitIdxW'(32'(wait_sum) - WaitDepth) : wait_sum[WaitIdxW-1:0];

  assign run_head_inc  = (32'(run_head_q) == RunSlots - 1) ?
                         '0 : run_head_q + RunIdxW'(1);
  assign wait_head_inc = (32'(wait_head_q) == WaitDepth - 1) ?
                         '0 : wait_head_q + WaitIdxW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (command_i == CMD_KILL) ? ST_KILL : ST_CREATE;
        end
      end
      ST_CREATE: state_d = ST_EMIT;
      ST_KILL: begin
        state_d = (run_cnt_q == '0) ? ST_EMIT : ST_WREAD;
      end
      ST_WREAD:  state_d = ST_WCHECK;
      ST_WCHECK: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free_i) begin
          state_d = more_q ? ST_WREAD : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    jid_d        = jid_q;
    jmem_d       = jmem_q;
    run_head_d   = run_head_q;
    run_cnt_d    = run_cnt_q;
    wait_head_d  = wait_head_q;
    wait_cnt_d   = wait_cnt_q;
    used_d       = used_q;
    pend_d       = pend_q;
    more_d       = more_q;
    run_we       = 1'b0;
    wait_we      = 1'b0;
    run_wdata    = '{id: jid_q, mem: jmem_q};
    wait_wdata   = '{id: jid_q, mem: jmem_q};
    in_ready_o   = 1'b0;
    emit_valid_o = 1'b0;
    emit_o       = pend_q;
    emit_o.last  = !more_q;
    alu_req_o    = '{op: ALU_ADD, a: used_q, b: jmem_q, cap: cfg_i.mem_capacity};

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          jid_d  = job_id_i;
          jmem_d = job_memory_i;
        end
      end

      ST_CREATE: begin
        more_d = 1'b0;
        pend_d = '{ev: EV_REJECTED, id: jid_q, mem: jmem_q, used: used_q,
                   jobs: JobsW'(run_cnt_q), last: 1'b1};
        if (jid_q == '0 || jmem_q == '0) begin
          pend_d.ev = EV_REJECTED;
        end else if (alu_rsp_i.le_cap && slot_free) begin
          run_we      = 1'b1;
          run_cnt_d   = run_cnt_q + RunCntW'(1);
          used_d      = alu_rsp_i.res[MemW-1:0];
          pend_d.ev   = EV_ADMITTED;
          pend_d.used = used_d;
          pend_d.jobs = JobsW'(run_cnt_d);
        end else if (32'(wait_cnt_q) >= WaitDepth) begin
          pend_d.ev = EV_REJECTED;
        end else begin
          wait_we    = 1'b1;
          wait_cnt_d = wait_cnt_q + WaitCntW'(1);
          pend_d.ev  = EV_QUEUED;
        end
      end

      ST_KILL: begin
        alu_req_o.op = ALU_SUB;
        alu_req_o.b  = run_rd_q.mem;
        more_d       = 1'b0;
        if (run_cnt_q == '0) begin
          pend_d = '{ev: EV_NO_KILL, id: '0, mem: '0, used: used_q,
                     jobs: JobsW'(run_cnt_q), last: 1'b1};
        end else begin
          run_head_d = run_head_inc;
          run_cnt_d  = run_cnt_q - RunCntW'(1);
          // A borrow means the freed amount exceeds what is held: clamp to zero.
          used_d     = alu_rsp_i.res[MemW] ? '0 : alu_rsp_i.res[MemW-1:0];
          pend_d = '{ev: EV_KILLED, id: run_rd_q.id, mem: run_rd_q.mem,
                     used: used_d, jobs: JobsW'(run_cnt_d), last: 1'b1};
        end
      end

      ST_WREAD: begin
      end

      ST_WCHECK: begin
        alu_req_o.b = wait_rd_q.mem;
        more_d = (wait_cnt_q != '0) && slot_free && alu_rsp_i.lt_cap;
      end

      ST_EMIT: begin
        emit_valid_o = 1'b1;
        // The sum is recomputed here for the job about to move over.
        alu_req_o.b  = wait_rd_q.mem;
        if (out_free_i && more_q) begin
          run_we      = 1'b1;
          run_wdata   = wait_rd_q;
          run_cnt_d   = run_cnt_q + RunCntW'(1);
          used_d      = alu_rsp_i.res[MemW-1:0];
          wait_head_d = wait_head_inc;
          wait_cnt_d  = wait_cnt_q - WaitCntW'(1);
          pend_d = '{ev: EV_ADMIT_WAIT, id: wait_rd_q.id, mem: wait_rd_q.mem,
                     used: used_d, jobs: JobsW'(run_cnt_d), last: 1'b1};
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_head_q  <= '0;
      run_cnt_q   <= '0;
      wait_head_q <= '0;
      wait_cnt_q  <= '0;
      used_q      <= '0;
      more_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_head_q  <= run_head_d;
      run_cnt_q   <= run_cnt_d;
      wait_head_q <= wait_head_d;
      wait_cnt_q  <= wait_cnt_d;
      used_q      <= used_d;
      more_q      <= more_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jid_q  <= jid_d;
    jmem_q <= jmem_d;
    pend_q <= pend_d;
  end

  // Queue storage: one write port each, head read registered every cycle.
  always_ff @(posedge clk_i) begin
    if (run_we) begin
      run_mem[run_widx] <= run_wdata;
    end
    run_rd_q <= run_mem[run_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (wait_we) begin
      wait_mem[wait_widx] <= wait_wdata;
    end
    wait_rd_q <= wait_mem[wait_head_q];
  end

endmodule

`default_nettype wire

@@ rtl/memory_slot_admission_scheduler_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid_i/in_ready_o   command_i, job_id_i, job_memory_i
// result    out_valid_o/out_ready_i event_res_o, event_job_id_o, event_job_memory_o,
//                                   memory_in_use_o, jobs_running_o, last_o
// config    cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// A create passes the CREATE and EMIT states, then the result register. A kill
// goes from KILL straight to EMIT when no job runs and through WREAD and WCHECK
// to EMIT otherwise; each job then admitted from the waiting queue passes
// through WREAD, WCHECK and EMIT again. The sequencer runs every sum and compare
// through one shared add/subtract unit and reads queue heads from registered
// memory ports. Reset clears the queue pointers, counts and memory in use, and
// sets the limits to eight jobs and 65535 units; queue contents are not cleared.
// A stalled result holds the sequencer until the result register frees up.

module memory_slot_admission_scheduler_unit import msas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [IdW-1:0]     job_id_i,
  input  logic [MemW-1:0]    job_memory_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_res_o,
  output logic [IdW-1:0]     event_job_id_o,
  output logic [MemW-1:0]    event_job_memory_o,
  output logic [MemW-1:0]    memory_in_use_o,
  output logic [JobsW-1:0]   jobs_running_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  logic [MaxRunW-1:0] max_running_q, max_running_d;
  logic [MemW-1:0]    mem_cap_q, mem_cap_d;
  cfg_t               cfg;

  logic     out_valid_q, out_valid_d;
  result_t  out_q, out_d;
  logic     out_free;
  logic     emit_valid;
  result_t  emit;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // Configuration writes land directly in their registers.
  always_comb begin
    max_running_d = max_running_q;
    mem_cap_d     = mem_cap_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_RUNNING:  max_running_d = cfg_wdata_i[MaxRunW-1:0];
        CFG_MEM_CAPACITY: mem_cap_d     = cfg_wdata_i[MemW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_running_q <= MaxRunReset;
      mem_cap_q     <= MemCapReset;
    end else begin
      max_running_q <= max_running_d;
      mem_cap_q     <= mem_cap_d;
    end
  end

  assign cfg = '{max_running: max_running_q, mem_capacity: mem_cap_q};

  msas_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  msas_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .job_id_i     (job_id_i),
    .job_memory_i (job_memory_i),
    .cfg_i        (cfg),
    .out_free_i   (out_free),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .alu_req_o    (alu_req),
    .alu_rsp_i    (alu_rsp)
  );

  // Result register: a new result is loaded when the slot is empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = emit_valid;
      if (emit_valid) begin
        out_d = emit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign event_res_o        = out_q.ev;
  assign event_job_id_o     = out_q.id;
  assign event_job_memory_o = out_q.mem;
  assign memory_in_use_o    = out_q.used;
  assign jobs_running_o     = out_q.jobs;
  assign last_o             = out_q.last;

endmodule

`default_nettype wire

@@ rtl/msas_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module msas_checker import msas_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire logic [2:0]       event_res_o,
  input wire logic [IdW-1:0]   event_job_id_o,
  input wire logic [MemW-1:0]  event_job_memory_o,
  input wire logic [JobsW-1:0] jobs_running_o,
  input wire logic             last_o
);

  // The block works on one item at a time.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // A waiting result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(event_res_o) && $stable(event_job_id_o) &&
       $stable(last_o)))
    else $error("stalled result changed");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_res_o <= EV_NO_KILL))
    else $error("undefined event code");

  a_jobs_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(jobs_running_o) <= RunSlots))
    else $error("more running jobs than slots");

  // A kill with nothing running ends the item and names no job.
  a_no_kill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_NO_KILL) |->
      (last_o && event_job_id_o == '0 && event_job_memory_o == '0))
    else $error("bad empty-kill result");

endmodule

bind memory_slot_admission_scheduler_unit msas_checker u_msas_checker (.*);

`default_nettype wire

@@ sim/tb_memory_slot_admission_scheduler_unit.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the job admission scheduler.
//
// Job requests sit in a queue that the stimulus block fills. A clocked sender
// takes them from there and offers each one on the input channel. At every
// input transfer the bench's own copy of the scheduler works out which events
// that request must cause. A clocked receiver takes the events off the output
// channel and checks each one against the oldest outstanding prediction. Both
// sides idle at random between transfers. Limits are changed only while the
// scheduler is quiet.
module tb_memory_slot_admission_scheduler_unit;
  import msas_pkg::*;

  // The drain already waits for every predicted event, so this pause only
  // lets the scheduler sit idle before the limits change.
  localparam int SettleCycles = 16;
  // The receiver holds off for this long once, so that the scheduler fills
  // up and stops taking requests.
  localparam int LongHold     = 400;
  localparam int CycleLimit   = 600000;

  typedef struct packed {
    cmd_e            cmd;
    logic [IdW-1:0]  id;
    logic [MemW-1:0] mem;
  } job_req_t;

  // Clock, reset and all inputs of the scheduler start at known values.
  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic             command_i    = 1'b0;
  logic [IdW-1:0]   job_id_i     = '0;
  logic [MemW-1:0]  job_memory_i = '0;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic [2:0]       event_res_o;
  logic [IdW-1:0]   event_job_id_o;
  logic [MemW-1:0]  event_job_memory_o;
  logic [MemW-1:0]  memory_in_use_o;
  logic [JobsW-1:0] jobs_running_o;
  logic             last_o;
  logic             cfg_we_i     = 1'b0;
  logic [0:0]       cfg_idx_i    = '0;
  logic [CfgW-1:0]  cfg_wdata_i  = '0;

  memory_slot_admission_scheduler_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .job_id_i           (job_id_i),
    .job_memory_i       (job_memory_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .event_res_o        (event_res_o),
    .event_job_id_o     (event_job_id_o),
    .event_job_memory_o (event_job_memory_o),
    .memory_in_use_o    (memory_in_use_o),
    .jobs_running_o     (jobs_running_o),
    .last_o             (last_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bench copy of the scheduler state. The limits start at their reset values.
  logic [IdW-1:0]     run_ids   [RunSlots];
  logic [MemW-1:0]    run_mems  [RunSlots];
  int                 run_rd    = 0;
  int                 run_cnt   = 0;
  logic [IdW-1:0]     wait_ids  [WaitDepth];
  logic [MemW-1:0]    wait_mems [WaitDepth];
  int                 wait_rd   = 0;
  int                 wait_cnt  = 0;
  logic [MemW-1:0]    mem_held  = '0;
  logic [MaxRunW-1:0] slot_cap  = MaxRunReset;
  logic [MemW-1:0]    mem_cap   = MemCapReset;

  result_t  expected_events[$];
  job_req_t pending_jobs[$];

  int jobs_planned = 0;
  int jobs_sent    = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  // Idling controls. The stimulus block sets the largest gap per phase and
  // asks for the long receiver hold by bumping hold_req.
  int tx_gap_max = 0;
  int rx_gap_max = 0;
  int hold_req   = 0;
  int hold_done  = 0;

  function automatic void log_event(input event_e ev, input logic [IdW-1:0] id,
                                    input logic [MemW-1:0] mem);
    result_t r;
    r.ev   = ev;
    r.id   = id;
    r.mem  = mem;
    r.used = mem_held;
    r.jobs = JobsW'(run_cnt);
    r.last = 1'b0;
    expected_events.push_back(r);
  endfunction

  function automatic void start_job(input logic [IdW-1:0] id, input logic [MemW-1:0] mem);
    int slot;
    slot = (run_rd + run_cnt) % RunSlots;
    run_ids[slot]  = id;
    run_mems[slot] = mem;
    run_cnt++;
    mem_held = mem_held + mem;
  endfunction

  // Works out every event that one request causes and updates the bench state.
  function automatic void schedule_job(input job_req_t req);
    int              lim;
    int              slot;
    logic [MemW:0]   sum;
    logic [IdW-1:0]  hid;
    logic [MemW-1:0] hmem;
    lim = (int'(slot_cap) < RunSlots) ? int'(slot_cap) : RunSlots;
    sum = {1'b0, mem_held} + {1'b0, req.mem};
    if (req.cmd == CMD_CREATE) begin
      if (req.id == '0 || req.mem == '0) begin
        log_event(EV_REJECTED, req.id, req.mem);
      end else if (sum <= {1'b0, mem_cap} && run_cnt < lim) begin
        start_job(req.id, req.mem);
        log_event(EV_ADMITTED, req.id, req.mem);
      end else if (wait_cnt >= WaitDepth) begin
        log_event(EV_REJECTED, req.id, req.mem);
      end else begin
        slot = (wait_rd + wait_cnt) % WaitDepth;
        wait_ids[slot]  = req.id;
        wait_mems[slot] = req.mem;
        wait_cnt++;
        log_event(EV_QUEUED, req.id, req.mem);
      end
    end else if (run_cnt == 0) begin
      log_event(EV_NO_KILL, '0, '0);
    end else begin
      hid    = run_ids[run_rd];
      hmem   = run_mems[run_rd];
      run_rd = (run_rd + 1) % RunSlots;
      run_cnt--;
      mem_held = (mem_held >= hmem) ? mem_held - hmem : '0;
      log_event(EV_KILLED, hid, hmem);
      // Waiting jobs move up in order; the head must fit strictly below the
      // capacity, and the first one that does not fit blocks the rest.
      while (wait_cnt > 0 && run_cnt < lim) begin
        hid  = wait_ids[wait_rd];
        hmem = wait_mems[wait_rd];
        sum  = {1'b0, mem_held} + {1'b0, hmem};
        if (sum >= {1'b0, mem_cap}) break;
        wait_rd = (wait_rd + 1) % WaitDepth;
        wait_cnt--;
        start_job(hid, hmem);
        log_event(EV_ADMIT_WAIT, hid, hmem);
      end
    end
    expected_events[$].last = 1'b1;
  endfunction

  // Sender. A request stays on the port until its transfer; after each
  // transfer the sender draws how many cycles it waits before the next one.
  int       send_gap = 0;
  job_req_t cur_job;

  always @(posedge clk_i) begin : tx_side
    logic valid_next;
    if (rst_ni) begin
      valid_next = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        schedule_job(cur_job);
        jobs_sent++;
        valid_next = 1'b0;
        send_gap   = $urandom_range(0, tx_gap_max);
      end
      if (!valid_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_jobs.size() > 0) begin
          cur_job      = pending_jobs.pop_front();
          command_i    <= cur_job.cmd;
          job_id_i     <= cur_job.id;
          job_memory_i <= cur_job.mem;
          valid_next   = 1'b1;
        end
      end
      in_valid_i <= valid_next;
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Receiver. Every event transfer is checked against the oldest prediction.
  // After each transfer the receiver draws a stall; the long hold overrides it.
  int rx_stall     = 0;
  int rx_hold_left = 0;

  always @(posedge clk_i) begin : rx_side
    logic    ready_next;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_events.size() == 0) begin
          $error("event %0d for job %0d arrived with nothing outstanding",
                 event_res_o, event_job_id_o);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", want.ev, event_res_o);
          check_field("event_job_id", want.id, event_job_id_o);
          check_field("event_job_memory", want.mem, event_job_memory_o);
          check_field("memory_in_use", want.used, memory_in_use_o);
          check_field("jobs_running", want.jobs, jobs_running_o);
          check_field("last", want.last, last_o);
        end
        rx_stall = $urandom_range(0, rx_gap_max);
      end
      if (hold_req != hold_done) begin
        rx_hold_left = LongHold;
        hold_done++;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        ready_next = 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready_i <= ready_next;
    end
  end

  task automatic queue_job(input cmd_e cmd, input logic [IdW-1:0] id,
                           input logic [MemW-1:0] mem);
    job_req_t req;
    req.cmd = cmd;
    req.id  = id;
    req.mem = mem;
    pending_jobs.push_back(req);
    jobs_planned++;
  endtask

  // A kill carries junk in its id and memory fields; the scheduler ignores them.
  task automatic queue_kill();
    queue_job(CMD_KILL, IdW'($urandom), MemW'($urandom));
  endtask

  // Waits until every request has had its transfer and every predicted event
  // has come back, then lets the scheduler settle.
  task automatic drain();
    while (!(jobs_sent == jobs_planned && expected_events.size() == 0))
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_RUNNING) slot_cap = value[MaxRunW-1:0];
    else                        mem_cap  = value[MemW-1:0];
  endtask

  // The upper bits of a slot-limit write are random; only the low bits count.
  task automatic set_limits(input logic [MaxRunW-1:0] max_run, input logic [MemW-1:0] cap);
    logic [CfgW-1:0] word;
    word                = CfgW'($urandom);
    word[MaxRunW-1:0]   = max_run;
    write_cfg(CFG_MAX_RUNNING, word);
    write_cfg(CFG_MEM_CAPACITY, CfgW'(cap));
  endtask

  // Queues a batch of random requests. Most creates ask for between one and
  // mem_hi units of memory; a few ask for any amount, and a few carry a
  // zero id or zero memory.
  task automatic random_jobs(input int count, input int kill_pct, input int mem_hi);
    logic [IdW-1:0]  id;
    logic [MemW-1:0] mem;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < kill_pct) begin
        queue_kill();
      end else begin
        id = IdW'($urandom);
        if (id == '0) id = IdW'(1);
        if ($urandom_range(0, 9) == 0) mem = MemW'($urandom);
        else                           mem = MemW'($urandom_range(1, mem_hi));
        if ($urandom_range(0, 24) == 0) id  = '0;
        if ($urandom_range(0, 24) == 0) mem = '0;
        queue_job(CMD_CREATE, id, mem);
      end
    end
  endtask

  task automatic set_idling(input int tx_max, input int rx_max);
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(19, 19);

    // Reset limits: empty kill, zero id or memory, an exact fit of the whole
    // capacity, and a kill that pulls a waiting job in.
    queue_kill();
    queue_job(CMD_CREATE, IdW'(0), MemW'(5));
    queue_job(CMD_CREATE, IdW'(7), MemW'(0));
    queue_job(CMD_CREATE, IdW'(0), MemW'(0));
    queue_job(CMD_CREATE, {IdW{1'b1}}, {MemW{1'b1}});
    queue_job(CMD_CREATE, IdW'(1), MemW'(1));
    queue_kill();
    queue_kill();
    drain();

    // Two slots and 100 units: an exact fit on create, then a waiting head
    // that needs exactly the remaining memory and so must stay behind.
    set_limits(MaxRunW'(2), MemW'(100));
    queue_job(CMD_CREATE, IdW'(10), MemW'(60));
    queue_job(CMD_CREATE, IdW'(11), MemW'(40));
    queue_job(CMD_CREATE, IdW'(12), MemW'(60));
    queue_job(CMD_CREATE, IdW'(13), MemW'(1));
    queue_kill();
    queue_kill();
    drain();

    // Capacity dropped below the memory in use: nothing is evicted and new
    // jobs wait until memory comes free.
    set_limits(MaxRunW'(2), MemW'(30));
    queue_job(CMD_CREATE, IdW'(14), MemW'(5));
    queue_kill();
    queue_kill();
    queue_kill();
    queue_kill();
    drain();

    set_limits(MaxRunW'(8), MemW'(65535));
    random_jobs(37, 40, 20000);
    drain();

    // One slot and creates mostly: the waiting queue fills and overflows.
    // No idling on either side here.
    set_idling(0, 0);
    set_limits(MaxRunW'(1), MemW'(65535));
    random_jobs(37, 15, 300);
    drain();

    // All eight slots open at once, so the first kill admits a long chain.
    set_idling(19, 19);
    set_limits(MaxRunW'(8), MemW'(2000));
    queue_kill();
    random_jobs(36, 55, 300);
    drain();

    // The receiver holds off while the sender keeps offering back to back.
    set_idling(0, 19);
    set_limits(MaxRunW'(3), MemW'(200));
    hold_req++;
    random_jobs(37, 35, 80);
    drain();

    // A slot limit of zero admits no create; valid creates queue until the waiting queue is full.
    set_idling(19, 19);
    set_limits(MaxRunW'(0), MemW'(1000));
    random_jobs(37, 30, 200);
    drain();

    // A slot limit above the number of slots behaves as the number of slots.
    set_limits(MaxRunW'(15), MemW'(4000));
    queue_kill();
    random_jobs(36, 50, 500);
    drain();

    set_limits(MaxRunW'(2), MemW'(1));
    random_jobs(37, 40, 2);
    drain();

    set_idling(5, 3);
    set_limits(MaxRunW'(8), MemW'(65535));
    random_jobs(37, 45, 65535);
    drain();

    set_idling(19, 0);
    set_limits(MaxRunW'(4), MemW'(30));
    random_jobs(37, 40, 12);
    drain();

    if (mismatches == 0) begin
      $display("memory_slot_admission_scheduler_unit verification clean");
    end else begin
      $display("memory_slot_admission_scheduler_unit verification failed");
    end
    $finish;
  end

  // Ends a run that hangs, for instance on a handshake that never completes.
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("memory_slot_admission_scheduler_unit verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/msas_pkg.sv
rtl/msas_alu.sv
rtl/msas_seq.sv
rtl/memory_slot_admission_scheduler_unit.sv
rtl/msas_checker.sv
sim/tb_memory_slot_admission_scheduler_unit.sv
